// ----- design/gntk_pkg.sv -----
// gntk_pkg: shared types and constants of the top-k neighbour select unit
// no dependencies; used by gntk_ctrl, gntk_dp and the top level
package gntk_pkg;

    localparam int MAX_KEEP = 16;
    localparam int IW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int FW = $clog2(MAX_KEEP + 1);
    localparam int KEYW = 48 + 16 + IW;

    localparam logic [1:0] OP_COORD = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic CFG_KEEP_COUNT    = 1'b0;
    localparam logic CFG_EXPLORE_LIMIT = 1'b1;

    localparam logic KIND_BEST = 1'b0;
    localparam logic KIND_KEPT = 1'b1;

    typedef struct packed {
        logic [1:0]         op;
        logic [15:0]        neighbor_id;
        logic signed [15:0] query_coord;
        logic signed [15:0] neighbor_coord;
        logic               last_coord;
        logic               last_neighbor;
    } t_in_item;

    typedef struct packed {
        logic        record_kind;
        logic [15:0] node_id;
        logic [47:0] distance;
        logic        found;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic exec;
        logic scan_step;
        logic replace;
        logic emit_best;
        logic sort_step;
        logic emit_ent;
        logic clear_q;
    } t_cmd;

    typedef struct packed {
        logic [1:0]    op;
        logic          lc;
        logic          ln;
        logic          stopped;
        logic          fill_lt_limit;
        logic          fill_zero;
        logic          scan_last;
        logic          pos_last;
        logic          out_free;
        logic [FW-1:0] fill;
    } t_sts;

endpackage

// ----- design/gntk_ctrl.sv -----
// gntk_ctrl: sequencing state machine of the top-k neighbour select unit
// depends on gntk_pkg; drives gntk_dp through t_cmd, reads t_sts
module gntk_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  gntk_pkg::t_sts i_sts,
    output gntk_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_SCAN, S_REPL, S_BEST, S_SORT, S_ENT
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_IDLE;
                if (i_sts.op == gntk_pkg::OP_COORD && i_sts.lc) begin
                    if (!i_sts.stopped && !i_sts.fill_lt_limit && !i_sts.fill_zero)
                        n_state = S_SCAN;
                    else if (i_sts.ln)
                        n_state = S_BEST;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) n_state = S_REPL;
            end
            S_REPL: begin
                o_cmd.replace = 1'b1;
                n_state       = i_sts.ln ? S_BEST : S_IDLE;
            end
            S_BEST: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_best = 1'b1;
                    if (i_sts.fill_zero) begin
                        o_cmd.clear_q = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        n_state = S_SORT;
                    end
                end
            end
            S_SORT: begin
                o_cmd.sort_step = 1'b1;
                if (i_sts.scan_last) n_state = S_ENT;
            end
            S_ENT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_ent = 1'b1;
                    if (i_sts.pos_last) begin
                        o_cmd.clear_q = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        n_state = S_SORT;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- design/gntk_dp.sv -----
// gntk_dp: distance accumulator, kept table, best tracker and output register
// depends on gntk_pkg; commanded by gntk_ctrl
module gntk_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gntk_pkg::t_in_item   i_item,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    input  gntk_pkg::t_cmd       i_cmd,
    output gntk_pkg::t_sts       o_sts,
    output logic                 o_valid,
    input  logic                 i_stall,
    output gntk_pkg::t_out_item  o_item
);

    localparam int IW   = gntk_pkg::IW;
    localparam int FW   = gntk_pkg::FW;
    localparam int KEYW = gntk_pkg::KEYW;
    // wide enough for keep_count, the table size and the fill count
    localparam int LW   = ((FW > 5) ? FW : 5) + 1;

    // configuration
    logic [4:0] r_keep;
    logic [7:0] r_limit;

    // latched item and squared difference
    logic [1:0]  r_op;
    logic [15:0] r_id;
    logic        r_lc;
    logic        r_ln;
    logic [33:0] r_sq;

    // query state
    logic [47:0] r_sum;
    logic [47:0] r_best_d;
    logic [15:0] r_best_n;
    logic        r_best_v;
    logic [8:0]  r_explored;
    logic        r_stopped;
    logic [47:0] r_d;

    // kept table
    logic [47:0] r_kd [gntk_pkg::MAX_KEEP];
    logic [15:0] r_kn [gntk_pkg::MAX_KEEP];
    logic [FW-1:0] r_fill;

    // scan and sort state
    logic [IW-1:0]   r_idx;
    logic            r_dup;
    logic [47:0]     r_max_d;
    logic [15:0]     r_max_n;
    logic [IW-1:0]   r_max_i;
    logic [KEYW-1:0] r_prev;
    logic            r_have_prev;
    logic [KEYW-1:0] r_cand;
    logic            r_cand_v;
    logic [FW-1:0]   r_pos;

    logic                r_ov;
    gntk_pkg::t_out_item r_out;

    logic signed [16:0] diff;
    logic signed [33:0] diff_w;
    logic [48:0]        sum_wide;
    logic [47:0]        n_sum;
    logic [LW-1:0]      lim;
    logic [47:0]        e_d;
    logic [15:0]        e_n;
    logic [KEYW-1:0]    key;
    logic               take;

    assign diff     = 17'(i_item.query_coord) - 17'(i_item.neighbor_coord);
    assign diff_w   = 34'(diff);
    assign sum_wide = {1'b0, r_sum} + 49'(r_sq);
    assign n_sum    = sum_wide[48] ? '1 : sum_wide[47:0];
    assign lim      = (LW'(r_keep) > LW'(gntk_pkg::MAX_KEEP)) ? LW'(gntk_pkg::MAX_KEEP)
                                                               : LW'(r_keep);
    assign e_d      = r_kd[r_idx];
    assign e_n      = r_kn[r_idx];
    assign key      = {e_d, e_n, r_idx};
    assign take     = (!r_have_prev || key > r_prev) && (!r_cand_v || key < r_cand);

    always_comb begin
        o_sts               = '0;
        o_sts.op            = r_op;
        o_sts.lc            = r_lc;
        o_sts.ln            = r_ln;
        o_sts.stopped       = r_stopped;
        o_sts.fill_lt_limit = LW'(r_fill) < lim;
        o_sts.fill_zero     = (r_fill == '0);
        o_sts.scan_last     = (FW'(r_idx) + FW'(1)) == r_fill;
        o_sts.pos_last      = (r_pos + FW'(1)) == r_fill;
        o_sts.out_free      = !r_ov || !i_stall;
        o_sts.fill          = r_fill;
    end

    assign o_valid = r_ov;
    assign o_item  = r_out;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep      <= 5'd8;
            r_limit     <= 8'd255;
            r_fill      <= '0;
            r_sum       <= '0;
            r_best_d    <= '1;
            r_best_n    <= '0;
            r_best_v    <= 1'b0;
            r_explored  <= '0;
            r_stopped   <= 1'b0;
            r_ov        <= 1'b0;
            r_op        <= gntk_pkg::OP_START;
            r_lc        <= 1'b0;
            r_ln        <= 1'b0;
            r_idx       <= '0;
            r_have_prev <= 1'b0;
            r_cand_v    <= 1'b0;
            r_pos       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    gntk_pkg::CFG_KEEP_COUNT:    r_keep  <= i_cfg_data[4:0];
                    gntk_pkg::CFG_EXPLORE_LIMIT: r_limit <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                r_op <= i_item.op;
                r_lc <= i_item.last_coord;
                r_ln <= i_item.last_neighbor;
            end
            if (i_cmd.exec) begin
                r_idx <= '0;
                case (r_op)
                    gntk_pkg::OP_START: begin
                        r_sum      <= '0;
                        r_best_d   <= '1;
                        r_best_n   <= '0;
                        r_best_v   <= 1'b0;
                        r_explored <= '0;
                        r_stopped  <= 1'b0;
                    end
                    gntk_pkg::OP_CLEAR: r_fill <= '0;
                    gntk_pkg::OP_COORD: begin
                        if (!r_stopped) begin
                            if (r_lc) begin
                                r_sum <= '0;
                                if (!r_best_v || n_sum < r_best_d) begin
                                    r_best_d <= n_sum;
                                    r_best_n <= r_id;
                                    r_best_v <= 1'b1;
                                end
                                if (r_explored >= 9'(r_limit)) r_stopped <= 1'b1;
                                else r_explored <= r_explored + 9'd1;
                                if (LW'(r_fill) < lim) r_fill <= r_fill + FW'(1);
                            end else begin
                                r_sum <= n_sum;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.scan_step) r_idx <= r_idx + IW'(1);
            if (i_cmd.emit_best) begin
                r_idx       <= '0;
                r_have_prev <= 1'b0;
                r_cand_v    <= 1'b0;
                r_pos       <= '0;
            end
            if (i_cmd.sort_step) begin
                r_idx <= r_idx + IW'(1);
                if (take) r_cand_v <= 1'b1;
            end
            if (i_cmd.emit_ent) begin
                r_idx       <= '0;
                r_have_prev <= 1'b1;
                r_cand_v    <= 1'b0;
                r_pos       <= r_pos + FW'(1);
            end
            if (i_cmd.clear_q) begin
                r_sum      <= '0;
                r_best_d   <= '1;
                r_best_n   <= '0;
                r_best_v   <= 1'b0;
                r_explored <= '0;
                r_stopped  <= 1'b0;
            end
            if (i_cmd.emit_best || i_cmd.emit_ent) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_id <= i_item.neighbor_id;
            r_sq <= diff_w * diff_w;
        end
        if (i_cmd.exec) r_d <= n_sum;
        if (i_cmd.exec && r_op == gntk_pkg::OP_COORD && !r_stopped && r_lc
            && LW'(r_fill) < lim) begin
            r_kd[r_fill[IW-1:0]] <= n_sum;
            r_kn[r_fill[IW-1:0]] <= r_id;
        end
        if (i_cmd.scan_step) begin
            if (r_idx == '0) begin
                r_dup   <= (e_n == r_id);
                r_max_d <= e_d;
                r_max_n <= e_n;
                r_max_i <= r_idx;
            end else begin
                if (e_n == r_id) r_dup <= 1'b1;
                if (e_d > r_max_d || (e_d == r_max_d && e_n >= r_max_n)) begin
                    r_max_d <= e_d;
                    r_max_n <= e_n;
                    r_max_i <= r_idx;
                end
            end
        end
        if (i_cmd.replace && !r_dup && r_d < r_max_d) begin
            r_kd[r_max_i] <= r_d;
            r_kn[r_max_i] <= r_id;
        end
        if (i_cmd.sort_step && take) r_cand <= key;
        if (i_cmd.emit_best) begin
            r_out.record_kind <= gntk_pkg::KIND_BEST;
            r_out.node_id     <= r_best_n;
            r_out.distance    <= r_best_d;
            r_out.found       <= r_best_v;
            r_out.last        <= (r_fill == '0);
        end
        if (i_cmd.emit_ent) begin
            r_prev            <= r_cand;
            r_out.record_kind <= gntk_pkg::KIND_KEPT;
            r_out.node_id     <= r_cand[IW +: 16];
            r_out.distance    <= r_cand[IW+16 +: 48];
            r_out.found       <= r_best_v;
            r_out.last        <= (r_pos + FW'(1)) == r_fill;
        end
    end

endmodule

// ----- design/graph_neighbor_topk_select_unit.sv -----
// graph_neighbor_topk_select_unit: top level of the top-k neighbour select unit
// depends on gntk_pkg, gntk_ctrl and gntk_dp
//
// usage
// - input channel i_valid/o_stall carries one item: a coordinate pair, a start
//   of query or a clear of the kept table (op field)
// - a coordinate item first registers its squared difference, then accumulates
//   it and, on a neighbour's last coordinate, updates the best neighbour
// - when a neighbour's last coordinate arrives with a full kept table and the
//   query not stopped, the table is scanned once, one entry a cycle
// - a query end emits one best record, then the kept entries sorted; each
//   sorted entry is found by a selection scan over the kept_fill entries
// - output channel o_valid/i_stall is fed from one output register; a stall
//   holds the record and pauses the report, no item is taken meanwhile
// - configuration (keep_count, explore_limit) is written through
//   i_cfg_we/i_cfg_idx/i_cfg_data while the unit is idle
// - reset: keep_count 8, explore_limit 255, kept table empty, query cleared;
//   no clearing pass is needed
module graph_neighbor_topk_select_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  gntk_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output gntk_pkg::t_out_item o_item,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [7:0]          i_cfg_data
);

    gntk_pkg::t_cmd cmd;   // controller commands to the datapath
    gntk_pkg::t_sts sts;   // datapath status back to the controller

    gntk_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    gntk_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (o_item)
    );

    // kept table never grows past its storage
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(sts.fill) <= gntk_pkg::MAX_KEEP)
        else $error("kept table fill beyond storage");

    // a record is only loaded when the output register can take it
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit_best || cmd.emit_ent) |-> sts.out_free)
        else $error("record loaded over a waiting record");

    // no item is taken while a report is in progress
    a_no_accept_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit_best || cmd.emit_ent || cmd.sort_step) |-> o_stall)
        else $error("item accepted during report");

    // a loaded record shows up on the output next cycle
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit_best || cmd.emit_ent) |=> o_valid)
        else $error("loaded record not presented");

endmodule
